// File: sv/swmc_pkg.sv
// shared types and codes for the sliding window mean / covariance block
// no dependencies
package swmc_pkg;

  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_MAX_DIM      = 4;
  localparam int ELEM_FIELDS      = 4;

  localparam logic [4:0] WLEN_RESET        = 5'd16;
  localparam logic       REG_WINDOW_LENGTH = 1'b0;

  localparam logic       OP_PUSH  = 1'b0;
  localparam logic       OP_CLEAR = 1'b1;

  localparam logic [1:0] STAT_ENTRY   = 2'd0;
  localparam logic [1:0] STAT_SKIPPED = 2'd1;
  localparam logic [1:0] STAT_CLEARED = 2'd2;

  localparam logic       KIND_MEAN = 1'b0;
  localparam logic       KIND_COV  = 1'b1;

  typedef struct packed {
    logic       latch_in;
    logic       write_en;
    logic       commit;
    logic       clear;
    logic       skip;
    logic       acc_clr;
    logic       rd_en;
    logic       add_rd;
    logic       latch_a;
    logic       mul;
    logic       add_prod;
    logic       slot_step;
    logic       div_start;
    logic       div_cov;
    logic       emit_mean;
    logic       emit_cov;
    logic       last;
    logic [1:0] elem;
    logic [1:0] row;
    logic [1:0] col;
  } swmc_cmd_t;

  typedef struct packed {
    logic       is_clear;
    logic       is_bad;
    logic       last_sample;
    logic       div_busy;
    logic       out_free;
    logic [2:0] dim;
  } swmc_status_t;

endpackage

// File: sv/sliding_window_mean_covariance.sv
// top level of the sliding window mean / covariance block
// depends on swmc_pkg, swmc_ctrl, swmc_dp
//
// usage
//   input channel (in_valid / in_stall): one beat is a push of a residual vector
//   (dimension plus up to four signed Q7.8 elements) or a clear of the window.
//   result channel (out_valid / out_stall): a push gives the mean entries then the
//   upper-triangle covariance entries row-major, last set on the final one; a
//   skipped push or a clear gives one beat with last set.
//   config: apb-style port, window_length at byte address 0, pready always high.
// timing
//   a push takes longer with a larger dimension and held count; the single-port
//   window memory and the one-bit-a-cycle divider set it. the accumulator width is
//   39 at a depth of 16. a clear or a skipped push does no window walk. the first
//   result is loaded once the mean walk of element 0 and its divide have ended.
// reset
//   window empty, dimension unlocked, window_length 16; no memory clearing pass.
// stall
//   a stalled result is held in the output register and the sequencer waits before
//   loading the next one; the next input beat is taken while the last result waits.
module sliding_window_mean_covariance #(
  parameter int WINDOW_DEPTH = swmc_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_DIM      = swmc_pkg::DEF_MAX_DIM
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [2:0]         in_dimension,
  input  logic signed [15:0] in_elem_0,
  input  logic signed [15:0] in_elem_1,
  input  logic signed [15:0] in_elem_2,
  input  logic signed [15:0] in_elem_3,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_kind,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [37:0] out_value,
  output logic [4:0]         out_sample_count,
  output logic               out_window_full,
  output logic               out_last
);

  swmc_pkg::swmc_cmd_t    cmd;
  swmc_pkg::swmc_status_t st;

  logic [4:0] wlen_r;
  logic       reg_hit;

  // one register, word address in bit 2
  assign reg_hit    = cfg_paddr[2] == swmc_pkg::REG_WINDOW_LENGTH;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? {27'd0, wlen_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= swmc_pkg::WLEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      wlen_r <= cfg_pwdata[4:0];
    end
  end

  // sequencer
  swmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // window memory, arithmetic and result register
  swmc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_DIM      (MAX_DIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .wlen             (wlen_r),
    .in_operation     (in_operation),
    .in_dimension     (in_dimension),
    .in_elem_0        (in_elem_0),
    .in_elem_1        (in_elem_1),
    .in_elem_2        (in_elem_2),
    .in_elem_3        (in_elem_3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_kind         (out_kind),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_sample_count (out_sample_count),
    .out_window_full  (out_window_full),
    .out_last         (out_last)
  );

endmodule

// File: sv/swmc_ctrl.sv
// sequencer for the window walk, divisions and result emission
// depends on swmc_pkg
module swmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swmc_pkg::swmc_status_t st,
  output swmc_pkg::swmc_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SINGLE, S_WRITE, S_COMMIT,
    S_MCLR, S_MRD, S_MADD, S_MDGO, S_MDWT, S_MEMIT,
    S_CCLR, S_CRDR, S_CRDC, S_CMUL, S_CACC, S_CDGO, S_CDWT, S_CEMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] r_r, r_nxt, c_r, c_nxt, w_r, w_nxt;
  logic [2:0] dim_m1;
  logic       r_end, c_end, w_end;

  assign dim_m1   = st.dim - 3'd1;
  assign r_end    = {1'b0, r_r} == dim_m1;
  assign c_end    = {1'b0, c_r} == dim_m1;
  assign w_end    = {1'b0, w_r} == dim_m1;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    w_nxt     = w_r;
    cmd       = '0;
    cmd.row   = r_r;
    cmd.col   = c_r;
    cmd.elem  = r_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        w_nxt = 2'd0;
        if (st.is_clear || st.is_bad) state_nxt = S_SINGLE;
        else                          state_nxt = S_WRITE;
      end
      S_SINGLE: begin
        if (st.out_free) begin
          cmd.clear = st.is_clear;
          cmd.skip  = !st.is_clear;
          state_nxt = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.write_en = 1'b1;
        cmd.elem     = w_r;
        w_nxt        = w_r + 2'd1;
        if (w_end) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        r_nxt      = 2'd0;
        state_nxt  = S_MCLR;
      end
      S_MCLR: begin
        cmd.acc_clr = 1'b1;
        state_nxt   = S_MRD;
      end
      S_MRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MADD;
      end
      S_MADD: begin
        cmd.add_rd    = 1'b1;
        cmd.slot_step = 1'b1;
        state_nxt     = st.last_sample ? S_MDGO : S_MRD;
      end
      S_MDGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MDWT;
      end
      S_MDWT: begin
        if (!st.div_busy) state_nxt = S_MEMIT;
      end
      S_MEMIT: begin
        if (st.out_free) begin
          cmd.emit_mean = 1'b1;
          if (r_end) begin
            r_nxt     = 2'd0;
            c_nxt     = 2'd0;
            state_nxt = S_CCLR;
          end else begin
            r_nxt     = r_r + 2'd1;
            state_nxt = S_MCLR;
          end
        end
      end
      S_CCLR: begin
        cmd.acc_clr = 1'b1;
        state_nxt   = S_CRDR;
      end
      S_CRDR: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CRDC;
      end
      S_CRDC: begin
        cmd.latch_a = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.elem    = c_r;
        state_nxt   = S_CMUL;
      end
      S_CMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.add_prod  = 1'b1;
        cmd.slot_step = 1'b1;
        state_nxt     = st.last_sample ? S_CDGO : S_CRDR;
      end
      S_CDGO: begin
        cmd.div_start = 1'b1;
        cmd.div_cov   = 1'b1;
        state_nxt     = S_CDWT;
      end
      S_CDWT: begin
        if (!st.div_busy) state_nxt = S_CEMIT;
      end
      S_CEMIT: begin
        if (st.out_free) begin
          cmd.emit_cov = 1'b1;
          cmd.last     = r_end && c_end;
          if (c_end) begin
            if (r_end) begin
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = r_r + 2'd1;
              c_nxt     = r_r + 2'd1;
              state_nxt = S_CCLR;
            end
          end else begin
            c_nxt     = c_r + 2'd1;
            state_nxt = S_CCLR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= 2'd0;
      c_r     <= 2'd0;
      w_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      w_r     <= w_nxt;
    end
  end

endmodule

// File: sv/swmc_dp.sv
// datapath: window memory, accumulator, multiplier, serial divider, output register
// depends on swmc_pkg
module swmc_dp #(
  parameter int WINDOW_DEPTH = swmc_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_DIM      = swmc_pkg::DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swmc_pkg::swmc_cmd_t  cmd,
  output swmc_pkg::swmc_status_t st,
  input  logic [4:0]           wlen,
  input  logic                 in_operation,
  input  logic [2:0]           in_dimension,
  input  logic signed [15:0]   in_elem_0,
  input  logic signed [15:0]   in_elem_1,
  input  logic signed [15:0]   in_elem_2,
  input  logic signed [15:0]   in_elem_3,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic                 out_kind,
  output logic [1:0]           out_row,
  output logic [1:0]           out_col,
  output logic signed [37:0]   out_value,
  output logic [4:0]           out_sample_count,
  output logic                 out_window_full,
  output logic                 out_last
);

  localparam int PTR_W   = $clog2(WINDOW_DEPTH);
  localparam int ENTRIES = WINDOW_DEPTH * MAX_DIM;
  localparam int ADDR_W  = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CNT_MAX = (WINDOW_DEPTH < 31) ? WINDOW_DEPTH : 31;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int ACC_RAW = 35 + $clog2(WINDOW_DEPTH);
  localparam int ACC_W   = (ACC_RAW > 38) ? ACC_RAW : 38;
  localparam int STEP_W  = $clog2(ACC_W + 1);
  localparam int DIM_MAX = (MAX_DIM < swmc_pkg::ELEM_FIELDS) ? MAX_DIM : swmc_pkg::ELEM_FIELDS;

  // input item
  logic               op_r;
  logic [2:0]         dim_r;
  logic signed [15:0] elem_r [swmc_pkg::ELEM_FIELDS];

  // window state
  logic [15:0]      store_r [ENTRIES];
  logic signed [15:0] rdata_r;
  logic [PTR_W-1:0] ptr_r, slot_r;
  logic [CNT_W-1:0] count_r, remain_r;
  logic [2:0]       lock_r;

  // arithmetic
  logic signed [15:0]    mean_r [swmc_pkg::ELEM_FIELDS];
  logic signed [17:0]    a_r, b_val;
  logic signed [35:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0]      dvd_r, quot;
  logic [CNT_W-1:0]      divisor_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W:0]        trial;
  logic                  neg_r, div_busy_r;
  logic [STEP_W-1:0]     step_r;

  logic [4:0]       eff5;
  logic [CNT_W-1:0] eff;
  logic [CNT_W:0]   inc;
  logic             full;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PTR_W-1:0] ptr_prev, slot_prev;
  logic             out_free;

  assign eff5 = (wlen == 5'd0) ? 5'd1 : ((wlen > 5'(CNT_MAX)) ? 5'(CNT_MAX) : wlen);
  assign eff  = CNT_W'(eff5);
  assign inc  = {1'b0, count_r} + 1'b1;
  assign full = 5'(count_r) >= eff5;

  assign waddr = ADDR_W'(32'(ptr_r) * 32'(MAX_DIM) + 32'(cmd.elem));
  assign raddr = ADDR_W'(32'(slot_r) * 32'(MAX_DIM) + 32'(cmd.elem));

  assign ptr_prev  = (ptr_r == '0) ? PTR_W'(WINDOW_DEPTH - 1) : ptr_r - 1'b1;
  assign slot_prev = (slot_r == '0) ? PTR_W'(WINDOW_DEPTH - 1) : slot_r - 1'b1;

  assign b_val = 18'(rdata_r) - 18'(mean_r[cmd.col]);
  assign trial = {rem_r, dvd_r[ACC_W-1]};
  assign quot  = neg_r ? (~dvd_r + 1'b1) : dvd_r;

  assign out_free       = !out_valid || !out_stall;
  assign st.is_clear    = op_r == swmc_pkg::OP_CLEAR;
  assign st.is_bad      = (dim_r == 3'd0) || (dim_r > 3'(DIM_MAX)) ||
                          ((lock_r != 3'd0) && (lock_r != dim_r));
  assign st.last_sample = remain_r == CNT_W'(1);
  assign st.div_busy    = div_busy_r;
  assign st.out_free    = out_free;
  assign st.dim         = dim_r;

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.write_en) store_r[waddr] <= elem_r[cmd.elem];
    if (cmd.rd_en)    rdata_r <= store_r[raddr];
  end

  // input capture and arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r      <= in_operation;
      dim_r     <= in_dimension;
      elem_r[0] <= in_elem_0;
      elem_r[1] <= in_elem_1;
      elem_r[2] <= in_elem_2;
      elem_r[3] <= in_elem_3;
    end
    if (cmd.acc_clr) begin
      acc_r  <= '0;
      slot_r <= ptr_prev;
      remain_r <= count_r;
    end else begin
      if (cmd.add_rd)   acc_r <= acc_r + ACC_W'(rdata_r);
      if (cmd.add_prod) acc_r <= acc_r + ACC_W'(prod_r);
      if (cmd.slot_step) begin
        slot_r   <= slot_prev;
        remain_r <= remain_r - 1'b1;
      end
    end
    if (cmd.latch_a) a_r <= 18'(rdata_r) - 18'(mean_r[cmd.row]);
    if (cmd.mul)     prod_r <= a_r * b_val;
    if (cmd.emit_mean) mean_r[cmd.row] <= quot[15:0];
    // restoring divide on the magnitude, one quotient bit a cycle
    if (cmd.div_start) begin
      neg_r     <= acc_r[ACC_W-1];
      dvd_r     <= acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
      rem_r     <= '0;
      divisor_r <= !cmd.div_cov ? count_r :
                   ((count_r > CNT_W'(1)) ? count_r - 1'b1 : CNT_W'(1));
    end else if (div_busy_r) begin
      if (trial >= {1'b0, divisor_r}) begin
        rem_r <= CNT_W'(trial - {1'b0, divisor_r});
        dvd_r <= {dvd_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT_W-1:0];
        dvd_r <= {dvd_r[ACC_W-2:0], 1'b0};
      end
    end
  end

  // control state: window bookkeeping, divider sequencing, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      count_r    <= '0;
      lock_r     <= 3'd0;
      div_busy_r <= 1'b0;
      step_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        ptr_r   <= '0;
        count_r <= '0;
        lock_r  <= 3'd0;
      end else if (cmd.commit) begin
        ptr_r   <= (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        count_r <= (inc > {1'b0, eff}) ? eff : inc[CNT_W-1:0];
        lock_r  <= dim_r;
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        step_r     <= STEP_W'(ACC_W);
      end else if (div_busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) div_busy_r <= 1'b0;
      end
      if (cmd.clear || cmd.skip || cmd.emit_mean || cmd.emit_cov) out_valid <= 1'b1;
      else if (!out_stall)                                        out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      out_status       <= swmc_pkg::STAT_CLEARED;
      out_kind         <= swmc_pkg::KIND_MEAN;
      out_row          <= 2'd0;
      out_col          <= 2'd0;
      out_value        <= '0;
      out_sample_count <= 5'd0;
      out_window_full  <= 1'b0;
      out_last         <= 1'b1;
    end else if (cmd.skip) begin
      out_status       <= swmc_pkg::STAT_SKIPPED;
      out_kind         <= swmc_pkg::KIND_MEAN;
      out_row          <= 2'd0;
      out_col          <= 2'd0;
      out_value        <= '0;
      out_sample_count <= 5'(count_r);
      out_window_full  <= full;
      out_last         <= 1'b1;
    end else if (cmd.emit_mean || cmd.emit_cov) begin
      out_status       <= swmc_pkg::STAT_ENTRY;
      out_kind         <= cmd.emit_cov ? swmc_pkg::KIND_COV : swmc_pkg::KIND_MEAN;
      out_row          <= cmd.row;
      out_col          <= cmd.emit_cov ? cmd.col : 2'd0;
      out_value        <= cmd.emit_cov ? quot[37:0] : 38'(signed'(quot[15:0]));
      out_sample_count <= 5'(count_r);
      out_window_full  <= full;
      out_last         <= cmd.emit_cov && cmd.last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear || cmd.skip || cmd.emit_mean || cmd.emit_cov) |-> out_free)
    else $error("result loaded while output register holds an untaken beat");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy_r)
    else $error("divider restarted while busy");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (lock_r == 3'd0) && (ptr_r == '0))
    else $error("clear left window state behind");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (count_r <= eff) && (count_r != '0))
    else $error("held count outside effective window length");

endmodule
